// File: rtl/kmtc_pkg.sv
// Package: shared constants and types of the k-mer transition counter.
package kmtc_pkg;

  localparam int INDEX_BITS_DEF = 10;
  localparam int COUNT_BITS_DEF = 16;

  localparam int COL_BITS       = 5;
  localparam int ROW_FIELD_BITS = 10;
  localparam int READ_BITS      = 16;
  localparam int NUC_SYM_BITS   = 2;
  localparam int PRO_SYM_BITS   = 5;
  localparam int STEPS_MAX      = 7;

  localparam int CFG_ADDR_BITS  = 3;
  localparam int CFG_DATA_BITS  = 32;

  // register word index taken from paddr[2]
  localparam logic REG_PROTEIN_MODE = 1'b0;
  localparam logic REG_CONTEXT_LEN  = 1'b1;

  typedef enum logic [1:0] {
    FUNC_SYMBOL = 2'd0,
    FUNC_START  = 2'd1,
    FUNC_READ   = 2'd2
  } func_t;

  typedef enum logic [1:0] {
    OP_NONE  = 2'd0,
    OP_COUNT = 2'd1,
    OP_READ  = 2'd2
  } op_t;

  typedef struct packed {
    op_t  op;
    logic clear;
  } s1_ctrl_t;

endpackage

// File: rtl/kmtc_ifs.sv
// Interfaces: input item channel and result item channel.
interface kmtc_in_if;
  logic       valid;
  logic       ready;
  logic [1:0] func;
  logic [4:0] symbol_code;
  logic       symbol_invalid;
  logic [9:0] read_row;
  logic [4:0] read_col;
  logic       clear_after_read;

  modport source (
    output valid, func, symbol_code, symbol_invalid, read_row, read_col, clear_after_read,
    input  ready
  );
  modport sink (
    input  valid, func, symbol_code, symbol_invalid, read_row, read_col, clear_after_read,
    output ready
  );
endinterface

interface kmtc_out_if;
  logic        valid;
  logic        ready;
  logic [15:0] read_count;
  logic        counted;
  logic        saturated;

  modport source (output valid, read_count, counted, saturated, input ready);
  modport sink (input valid, read_count, counted, saturated, output ready);
endinterface

// File: rtl/kmtc_seq_ctx.sv
// Sequence context: previous symbol, prefix, skip and step state; memory address build.
module kmtc_seq_ctx #(
  parameter int INDEX_BITS = kmtc_pkg::INDEX_BITS_DEF
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 accept,
  input  logic [1:0]                           func,
  input  logic [4:0]                           symbol_code,
  input  logic                                 symbol_invalid,
  input  logic [kmtc_pkg::ROW_FIELD_BITS-1:0]  read_row,
  input  logic [kmtc_pkg::COL_BITS-1:0]        read_col,
  input  logic                                 clear_after_read,
  input  logic                                 protein_mode,
  input  logic [2:0]                           context_len,
  output logic [INDEX_BITS+kmtc_pkg::COL_BITS-1:0] rd_addr,
  output kmtc_pkg::s1_ctrl_t                   ctrl
);
  import kmtc_pkg::*;

  localparam int PW = INDEX_BITS + COL_BITS;
  localparam logic [3:0] LIMIT_NUC = 4'(INDEX_BITS / NUC_SYM_BITS);
  localparam logic [3:0] LIMIT_PRO = 4'(INDEX_BITS / PRO_SYM_BITS);

  logic [4:0]            prev_r, prev_nxt;
  logic                  have_r, have_nxt;
  logic [INDEX_BITS-1:0] ctx_r, ctx_nxt;
  logic [3:0]            skip_r, skip_nxt;
  logic [2:0]            steps_r, steps_nxt;

  logic [3:0]            limit;
  logic [3:0]            k;
  logic [6:0]            mask_len;
  logic [INDEX_BITS-1:0] mask;
  logic [4:0]            sym;
  logic                  inv;
  logic [PW-1:0]         shifted;
  logic [INDEX_BITS-1:0] prefix_new;
  logic [2:0]            steps_new;
  logic [3:0]            skip_cur;
  logic                  do_count;

  always_comb begin
    limit = protein_mode ? LIMIT_PRO : LIMIT_NUC;
    k = ({1'b0, context_len} > limit) ? limit : {1'b0, context_len};
    if (k == 4'd0) begin
      k = 4'd1;
    end
    mask_len = protein_mode ? 7'(k * 3'd5) : 7'(k * 3'd2);
    for (int i = 0; i < INDEX_BITS; i++) begin
      mask[i] = (7'(i) < mask_len);
    end

    sym = protein_mode ? symbol_code : {3'b000, symbol_code[1:0]};
    inv = protein_mode & symbol_invalid;

    shifted = protein_mode ? (PW'(ctx_r) << PRO_SYM_BITS) : (PW'(ctx_r) << NUC_SYM_BITS);
    shifted = shifted | PW'(prev_r);
    prefix_new = have_r ? (INDEX_BITS'(shifted) & mask) : ctx_r;
    steps_new = (have_r && steps_r != 3'(STEPS_MAX)) ? steps_r + 3'd1 : steps_r;

    skip_cur = inv ? (k + 4'd1) : skip_r;
    do_count = (skip_cur == 4'd0) && have_r && ({1'b0, steps_new} >= k);

    // hold by default
    prev_nxt  = prev_r;
    have_nxt  = have_r;
    ctx_nxt   = ctx_r;
    skip_nxt  = skip_r;
    steps_nxt = steps_r;
    ctrl.op    = OP_NONE;
    ctrl.clear = clear_after_read;
    rd_addr    = {prefix_new, sym};

    case (func)
      FUNC_SYMBOL: begin
        prev_nxt  = sym;
        have_nxt  = 1'b1;
        ctx_nxt   = prefix_new;
        steps_nxt = steps_new;
        skip_nxt  = (skip_cur != 4'd0) ? skip_cur - 4'd1 : 4'd0;
        if (do_count) begin
          ctrl.op = OP_COUNT;
        end
      end
      FUNC_START: begin
        prev_nxt  = '0;
        have_nxt  = 1'b0;
        ctx_nxt   = '0;
        skip_nxt  = '0;
        steps_nxt = '0;
      end
      FUNC_READ: begin
        ctrl.op = OP_READ;
        rd_addr = {INDEX_BITS'(read_row), read_col};
      end
      default: begin
        ctrl.op = OP_NONE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prev_r  <= '0;
      have_r  <= 1'b0;
      ctx_r   <= '0;
      skip_r  <= '0;
      steps_r <= '0;
    end else if (accept) begin
      prev_r  <= prev_nxt;
      have_r  <= have_nxt;
      ctx_r   <= ctx_nxt;
      skip_r  <= skip_nxt;
      steps_r <= steps_nxt;
    end
  end

endmodule

// File: rtl/kmtc_count_mem.sv
// Count store: registered-read memory with write forwarding and a clearing pass after reset.
module kmtc_count_mem #(
  parameter int ADDR_BITS  = kmtc_pkg::INDEX_BITS_DEF + kmtc_pkg::COL_BITS,
  parameter int COUNT_BITS = kmtc_pkg::COUNT_BITS_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  rd_en,
  input  logic [ADDR_BITS-1:0]  rd_addr,
  output logic [COUNT_BITS-1:0] rd_data,
  input  logic                  wr_en,
  input  logic [ADDR_BITS-1:0]  wr_addr,
  input  logic [COUNT_BITS-1:0] wr_data,
  output logic                  busy
);
  localparam int DEPTH = 1 << ADDR_BITS;

  logic [COUNT_BITS-1:0] mem [DEPTH];
  logic [COUNT_BITS-1:0] q_r;
  logic [COUNT_BITS-1:0] fwd_data_r;
  logic                  fwd_hit_r;
  logic                  busy_r;
  logic [ADDR_BITS-1:0]  clr_addr_r;

  logic                  we;
  logic [ADDR_BITS-1:0]  wa;
  logic [COUNT_BITS-1:0] wd;

  always_comb begin
    we = busy_r | wr_en;
    wa = busy_r ? clr_addr_r : wr_addr;
    wd = busy_r ? '0 : wr_data;
  end

  always_ff @(posedge clk) begin
    if (we) begin
      mem[wa] <= wd;
    end
    if (rd_en) begin
      q_r <= mem[rd_addr];
    end
  end

  // a write landing on the address read at the same edge wins
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fwd_hit_r <= 1'b0;
    end else if (rd_en) begin
      fwd_hit_r <= we && (wa == rd_addr);
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      fwd_data_r <= wd;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r     <= 1'b1;
      clr_addr_r <= '0;
    end else if (busy_r) begin
      clr_addr_r <= clr_addr_r + 1'b1;
      if (&clr_addr_r) begin
        busy_r <= 1'b0;
      end
    end
  end

  assign rd_data = fwd_hit_r ? fwd_data_r : q_r;
  assign busy    = busy_r;

endmodule

// File: rtl/kmtc_update.sv
// Update stage: increment, saturate or read/clear an entry, then register the result item.
module kmtc_update #(
  parameter int ADDR_BITS  = kmtc_pkg::INDEX_BITS_DEF + kmtc_pkg::COL_BITS,
  parameter int COUNT_BITS = kmtc_pkg::COUNT_BITS_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  load,
  input  kmtc_pkg::s1_ctrl_t    ctrl_in,
  input  logic [ADDR_BITS-1:0]  addr_in,
  input  logic [COUNT_BITS-1:0] rd_data,
  output logic                  s1_free,
  output logic                  wr_en,
  output logic [ADDR_BITS-1:0]  wr_addr,
  output logic [COUNT_BITS-1:0] wr_data,
  kmtc_out_if.source            out_ch
);
  import kmtc_pkg::*;

  logic                  s1_valid_r;
  s1_ctrl_t              s1_ctrl_r;
  logic [ADDR_BITS-1:0]  s1_addr_r;

  logic                  out_valid_r;
  logic [READ_BITS-1:0]  read_count_r, read_count_nxt;
  logic                  counted_r, counted_nxt;
  logic                  saturated_r, saturated_nxt;

  logic                  out_free;
  logic                  adv;

  assign out_free = ~out_valid_r | out_ch.ready;
  assign adv      = s1_valid_r & out_free;
  assign s1_free  = ~s1_valid_r | out_free;
  assign wr_addr  = s1_addr_r;

  always_comb begin
    wr_en          = 1'b0;
    wr_data        = '0;
    read_count_nxt = '0;
    counted_nxt    = 1'b0;
    saturated_nxt  = 1'b0;
    case (s1_ctrl_r.op)
      OP_COUNT: begin
        if (&rd_data) begin
          saturated_nxt = 1'b1;
        end else begin
          wr_en       = adv;
          wr_data     = rd_data + 1'b1;
          counted_nxt = 1'b1;
        end
      end
      OP_READ: begin
        read_count_nxt = READ_BITS'(rd_data);
        wr_en          = adv & s1_ctrl_r.clear;
      end
      default: begin
        wr_en = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (load) begin
        s1_valid_r <= 1'b1;
      end else if (adv) begin
        s1_valid_r <= 1'b0;
      end
      if (adv) begin
        out_valid_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      s1_ctrl_r <= ctrl_in;
      s1_addr_r <= addr_in;
    end
    if (adv) begin
      read_count_r <= read_count_nxt;
      counted_r    <= counted_nxt;
      saturated_r  <= saturated_nxt;
    end
  end

  assign out_ch.valid      = out_valid_r;
  assign out_ch.read_count = read_count_r;
  assign out_ch.counted    = counted_r;
  assign out_ch.saturated  = saturated_r;

endmodule

// File: rtl/kmer_transition_counter.sv
// Top level: order-k Markov transition counter with count store and config registers.
//
//  channel  | dir | handshake            | payload
//  ---------+-----+----------------------+---------------------------------------------
//  in_ch    | in  | valid/ready          | func, symbol_code, symbol_invalid, read_row,
//           |     |                      | read_col, clear_after_read
//  out_ch   | out | valid/ready          | read_count, counted, saturated
//  apb      | in  | psel/penable/pwrite  | paddr, pwdata, prdata (pready tied high)
//
// One item per cycle while out_ch is not stalled: the store does one read and one write a
// cycle, and a write to the entry read at the same edge is forwarded into the update stage.
// An accepted item passes through the update stage register into the output register.
// After reset a clearing pass zeroes all 2^INDEX_BITS * 32 entries (32768 at the default);
// no item is taken meanwhile, register writes are. A stalled output holds the result register
// and the update stage; in_ch.ready drops only when both are full or the store is clearing.
module kmer_transition_counter #(
  parameter int INDEX_BITS = kmtc_pkg::INDEX_BITS_DEF,
  parameter int COUNT_BITS = kmtc_pkg::COUNT_BITS_DEF
) (
  input  logic                                clk,
  input  logic                                rst_n,
  kmtc_in_if.sink                             in_ch,
  kmtc_out_if.source                          out_ch,
  input  logic                                psel,
  input  logic                                penable,
  input  logic                                pwrite,
  input  logic [kmtc_pkg::CFG_ADDR_BITS-1:0]  paddr,
  input  logic [kmtc_pkg::CFG_DATA_BITS-1:0]  pwdata,
  output logic [kmtc_pkg::CFG_DATA_BITS-1:0]  prdata,
  output logic                                pready
);
  import kmtc_pkg::*;

  localparam int ADDR_BITS = INDEX_BITS + COL_BITS;

  logic                  protein_mode_r;
  logic [2:0]            context_len_r;
  logic                  cfg_wr;

  logic                  accept;
  logic                  busy;
  logic                  s1_free;
  s1_ctrl_t              ctrl;
  logic [ADDR_BITS-1:0]  rd_addr;
  logic [COUNT_BITS-1:0] rd_data;
  logic                  wr_en;
  logic [ADDR_BITS-1:0]  wr_addr;
  logic [COUNT_BITS-1:0] wr_data;

  // Config registers: word index sits in paddr[2], byte offset bits are ignored.
  assign pready = 1'b1;
  assign cfg_wr = psel & penable & pwrite & pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      protein_mode_r <= 1'b0;
      context_len_r  <= 3'd1;
    end else if (cfg_wr) begin
      case (paddr[2])
        REG_PROTEIN_MODE: protein_mode_r <= pwdata[0];
        REG_CONTEXT_LEN:  context_len_r  <= pwdata[2:0];
        default:          protein_mode_r <= protein_mode_r;
      endcase
    end
  end

  always_comb begin
    case (paddr[2])
      REG_PROTEIN_MODE: prdata = CFG_DATA_BITS'(protein_mode_r);
      REG_CONTEXT_LEN:  prdata = CFG_DATA_BITS'(context_len_r);
      default:          prdata = '0;
    endcase
  end

  // Take an item when the store is cleared and the update stage can move on.
  assign in_ch.ready = ~busy & s1_free;
  assign accept      = in_ch.valid & in_ch.ready;

  kmtc_seq_ctx #(
    .INDEX_BITS (INDEX_BITS)
  ) u_seq_ctx (
    .clk              (clk),
    .rst_n            (rst_n),
    .accept           (accept),
    .func             (in_ch.func),
    .symbol_code      (in_ch.symbol_code),
    .symbol_invalid   (in_ch.symbol_invalid),
    .read_row         (in_ch.read_row),
    .read_col         (in_ch.read_col),
    .clear_after_read (in_ch.clear_after_read),
    .protein_mode     (protein_mode_r),
    .context_len      (context_len_r),
    .rd_addr          (rd_addr),
    .ctrl             (ctrl)
  );

  // Read the entry at acceptance; the update stage writes it back when it moves to the output register.
  kmtc_count_mem #(
    .ADDR_BITS  (ADDR_BITS),
    .COUNT_BITS (COUNT_BITS)
  ) u_count_mem (
    .clk     (clk),
    .rst_n   (rst_n),
    .rd_en   (accept),
    .rd_addr (rd_addr),
    .rd_data (rd_data),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .busy    (busy)
  );

  kmtc_update #(
    .ADDR_BITS  (ADDR_BITS),
    .COUNT_BITS (COUNT_BITS)
  ) u_update (
    .clk     (clk),
    .rst_n   (rst_n),
    .load    (accept),
    .ctrl_in (ctrl),
    .addr_in (rd_addr),
    .rd_data (rd_data),
    .s1_free (s1_free),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .out_ch  (out_ch)
  );

endmodule
